// ===== hdl/mpie_pkg.sv =====
// Shared types, field codes and constants for the mid-range PIC executor.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mpie_pkg;

  // Return stack geometry
  localparam int STACK_DEPTH = 8;
  localparam int SP_W        = $clog2(STACK_DEPTH);

  // STATUS bit positions
  localparam int FLAG_C  = 0;
  localparam int FLAG_DC = 1;
  localparam int FLAG_Z  = 2;
  localparam int FLAG_PD = 3;
  localparam int FLAG_TO = 4;

  localparam logic [7:0] STATUS_RESET = 8'h18;
  localparam logic [6:0] ADDR_STATUS  = 7'h03;
  localparam logic [6:0] CODE_RETURN  = 7'h08;
  localparam logic [6:0] CODE_RETFIE  = 7'h09;
  localparam logic [6:0] CODE_SLEEP   = 7'h63;
  localparam logic [6:0] CODE_CLRWDT  = 7'h64;
  localparam logic [12:0] INT_VECTOR  = 13'h0004;

  // Item command codes
  localparam logic CMD_EXEC = 1'b0;
  localparam logic CMD_INT  = 1'b1;

  // Opcode groups, instruction bits 13:11
  localparam logic [2:0] OPG_BYTE0 = 3'd0;
  localparam logic [2:0] OPG_BYTE1 = 3'd1;
  localparam logic [2:0] OPG_BITSC = 3'd2;
  localparam logic [2:0] OPG_BITTS = 3'd3;
  localparam logic [2:0] OPG_CALL  = 3'd4;
  localparam logic [2:0] OPG_GOTO  = 3'd5;
  localparam logic [2:0] OPG_MOVLW = 3'd6;
  localparam logic [2:0] OPG_LIT   = 3'd7;

  // Sub-operations, instruction bits 10:8, group 0
  localparam logic [2:0] SUB0_MISC  = 3'd0;
  localparam logic [2:0] SUB0_CLR   = 3'd1;
  localparam logic [2:0] SUB0_SUBWF = 3'd2;
  localparam logic [2:0] SUB0_DECF  = 3'd3;
  localparam logic [2:0] SUB0_IORWF = 3'd4;
  localparam logic [2:0] SUB0_ANDWF = 3'd5;
  localparam logic [2:0] SUB0_XORWF = 3'd6;
  localparam logic [2:0] SUB0_ADDWF = 3'd7;

  // Sub-operations, group 1
  localparam logic [2:0] SUB1_MOVF   = 3'd0;
  localparam logic [2:0] SUB1_COMF   = 3'd1;
  localparam logic [2:0] SUB1_INCF   = 3'd2;
  localparam logic [2:0] SUB1_DECFSZ = 3'd3;
  localparam logic [2:0] SUB1_RRF    = 3'd4;
  localparam logic [2:0] SUB1_RLF    = 3'd5;
  localparam logic [2:0] SUB1_SWAPF  = 3'd6;
  localparam logic [2:0] SUB1_INCFSZ = 3'd7;

  // Sub-operations, literal group
  localparam logic [2:0] SUBL_IORLW = 3'd0;
  localparam logic [2:0] SUBL_ANDLW = 3'd1;
  localparam logic [2:0] SUBL_XORLW = 3'd2;
  localparam logic [2:0] SUBL_NOP   = 3'd3;
  localparam logic [2:0] SUBL_SUB0  = 3'd4;
  localparam logic [2:0] SUBL_SUB1  = 3'd5;

  // Cycle counts reported
  localparam logic [1:0] CYC_NONE = 2'd0;
  localparam logic [1:0] CYC_ONE  = 2'd1;
  localparam logic [1:0] CYC_TWO  = 2'd2;

  // Stack fault codes
  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_OVER  = 2'd1;
  localparam logic [1:0] FAULT_UNDER = 2'd2;

  typedef enum logic [1:0] {
    DEST_NONE = 2'd0,
    DEST_W    = 2'd1,
    DEST_F    = 2'd2
  } dest_t;

  typedef struct packed {
    logic        command;
    logic [13:0] instruction;
    logic [7:0]  file_value;
    logic        gie_now;
    logic        interrupt_pending;
  } item_t;

  typedef struct packed {
    logic [12:0] pc;
    logic [7:0]  w;
    logic [7:0]  status;
    logic        sleeping;
  } arch_t;

  typedef struct packed {
    logic        push;
    logic        pop;
    logic [12:0] push_data;
  } stk_ctl_t;

  typedef struct packed {
    logic [12:0] pc_next;
    logic [7:0]  w_value;
    logic [7:0]  status_value;
    logic        file_write;
    logic [6:0]  file_addr;
    logic [7:0]  file_data;
    logic        gie_set;
    logic        gie_clear;
    logic [1:0]  cycles;
    logic [1:0]  stack_fault;
    logic        asleep;
  } result_t;

endpackage

// ===== hdl/mpie_stack.sv =====
// Wrapping return stack with its pointer and fault detection.
// Depends on mpie_pkg for depth and the control struct.
`timescale 1ns / 1ps

module mpie_stack (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  mpie_pkg::stk_ctl_t  ctl,
  output logic [12:0]         pop_data,
  output logic [1:0]          fault
);
  import mpie_pkg::*;

  logic [12:0]       entry_r [STACK_DEPTH];
  logic [SP_W-1:0]   sp_r;
  logic [SP_W-1:0]   sp_nxt;
  logic [SP_W-1:0]   sp_inc;
  logic [SP_W-1:0]   sp_dec;
  logic [SP_W:0]     sp_sum;

  // Wrap the pointer modulo the depth in both directions
  assign sp_sum = {1'b0, sp_r} + {{SP_W{1'b0}}, 1'b1};
  assign sp_inc = (sp_sum == STACK_DEPTH[SP_W:0]) ? '0 : sp_sum[SP_W-1:0];
  assign sp_dec = (sp_r == '0) ? SP_W'(STACK_DEPTH - 1) : sp_r - 1'b1;

  // Read the entry below the pointer, the one a pop returns
  assign pop_data = entry_r[sp_dec];

  // Flag overflow on a wrapping push, underflow on a pop from empty
  always_comb begin
    fault  = FAULT_NONE;
    sp_nxt = sp_r;
    if (ctl.push) begin
      sp_nxt = sp_inc;
      if (sp_inc == '0) fault = FAULT_OVER;
    end else if (ctl.pop) begin
      sp_nxt = sp_dec;
      if (sp_r == '0) fault = FAULT_UNDER;
    end
  end

  // Advance the pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else if (en) begin
      sp_r <= sp_nxt;
    end
  end

  // Write pushed return addresses
  always_ff @(posedge clk) begin
    if (en && ctl.push) begin
      entry_r[sp_r] <= ctl.push_data;
    end
  end

endmodule

// ===== hdl/mpie_exec.sv =====
// Single-pass decode and execute of one instruction or interrupt event.
// Depends on mpie_pkg; pure combinational logic.
`timescale 1ns / 1ps

module mpie_exec (
  input  mpie_pkg::item_t     item,
  input  mpie_pkg::arch_t     arch,
  input  logic [12:0]         pop_data,
  output mpie_pkg::arch_t     arch_nxt,
  output mpie_pkg::stk_ctl_t  stk,
  output mpie_pkg::result_t   res_o
);
  import mpie_pkg::*;

  logic [13:0] ins;
  logic [2:0]  opg;
  logic [2:0]  sub;
  logic [6:0]  fa;
  logic [7:0]  fv;
  logic [7:0]  lit;
  logic [7:0]  bmask;
  logic        bit_set;
  logic [12:0] pc_inc;
  logic [12:0] pc_skip;
  logic [7:0]  opa;
  logic [8:0]  add_sum;
  logic [4:0]  add_nib;
  logic        sub_c;
  logic        sub_dc;
  logic        sub_z;
  logic [7:0]  sub_res;
  logic [7:0]  inc_res;
  logic [7:0]  dec_res;

  // Decode operand fields
  assign ins     = item.instruction;
  assign opg     = ins[13:11];
  assign sub     = ins[10:8];
  assign fa      = ins[6:0];
  assign lit     = ins[7:0];
  assign fv      = (fa == ADDR_STATUS) ? arch.status : item.file_value;
  assign bmask   = 8'h01 << ins[9:7];
  assign bit_set = |(fv & bmask);
  assign pc_inc  = arch.pc + 13'd1;
  assign pc_skip = arch.pc + 13'd2;

  // Shared adder and subtractor: W against file value or literal
  assign opa     = (opg == OPG_LIT) ? lit : fv;
  assign add_sum = {1'b0, opa} + {1'b0, arch.w};
  assign add_nib = {1'b0, opa[3:0]} + {1'b0, arch.w[3:0]};
  assign sub_res = opa - arch.w;
  assign sub_c   = arch.w <= opa;
  assign sub_dc  = arch.w[3:0] <= opa[3:0];
  assign sub_z   = arch.w == opa;
  assign inc_res = fv + 8'd1;
  assign dec_res = fv - 8'd1;

  always_comb begin
    logic [7:0] r;
    logic [7:0] st;
    logic [7:0] aff;
    logic [7:0] keep;
    dest_t      dest;

    r    = '0;
    st   = arch.status;
    aff  = '0;
    keep = '0;
    dest = DEST_NONE;

    arch_nxt       = arch;
    arch_nxt.pc    = pc_inc;
    stk.push       = 1'b0;
    stk.pop        = 1'b0;
    stk.push_data  = pc_inc;
    res_o          = '0;
    res_o.cycles   = CYC_ONE;

    if (item.command == CMD_INT) begin
      // Interrupt: vector when enabled, always wake
      arch_nxt.pc = arch.pc;
      res_o.cycles = CYC_NONE;
      if (item.gie_now) begin
        stk.push        = 1'b1;
        stk.push_data   = arch.pc;
        arch_nxt.pc     = INT_VECTOR;
        res_o.gie_clear = 1'b1;
        res_o.cycles    = CYC_TWO;
      end
      arch_nxt.sleeping = 1'b0;
    end else if (arch.sleeping) begin
      // Hold everything while asleep
      arch_nxt.pc  = arch.pc;
      res_o.cycles = CYC_NONE;
    end else begin
      case (opg)
        OPG_BYTE0: begin
          case (sub)
            SUB0_MISC: begin
              if (ins[7]) begin
                r    = arch.w;
                dest = DEST_F;
              end else if (fa == CODE_CLRWDT) begin
                st[FLAG_TO] = 1'b1;
                st[FLAG_PD] = 1'b1;
              end else if (fa == CODE_RETFIE) begin
                stk.pop       = 1'b1;
                arch_nxt.pc   = pop_data;
                res_o.gie_set = 1'b1;
                res_o.cycles  = CYC_TWO;
              end else if (fa == CODE_RETURN) begin
                stk.pop      = 1'b1;
                arch_nxt.pc  = pop_data;
                res_o.cycles = CYC_TWO;
              end else if (fa == CODE_SLEEP) begin
                if (!item.interrupt_pending) begin
                  arch_nxt.sleeping = 1'b1;
                  st[FLAG_TO] = 1'b1;
                  st[FLAG_PD] = 1'b0;
                end
              end
            end
            SUB0_CLR: begin
              r          = '0;
              aff[FLAG_Z] = 1'b1;
              st[FLAG_Z]  = 1'b1;
            end
            SUB0_SUBWF: begin
              r = sub_res;
              aff[FLAG_C] = 1'b1; aff[FLAG_DC] = 1'b1; aff[FLAG_Z] = 1'b1;
              st[FLAG_C] = sub_c; st[FLAG_DC] = sub_dc; st[FLAG_Z] = sub_z;
            end
            SUB0_DECF:  r = dec_res;
            SUB0_IORWF: r = fv | arch.w;
            SUB0_ANDWF: r = fv & arch.w;
            SUB0_XORWF: r = fv ^ arch.w;
            default: begin
              r = add_sum[7:0];
              aff[FLAG_C] = 1'b1; aff[FLAG_DC] = 1'b1; aff[FLAG_Z] = 1'b1;
              st[FLAG_C]  = add_sum[8];
              st[FLAG_DC] = add_nib[4];
              st[FLAG_Z]  = add_sum[7:0] == 8'h00;
            end
          endcase
          // Logic ops and decrement touch only Z
          if (sub != SUB0_MISC && sub != SUB0_CLR && sub != SUB0_SUBWF &&
              sub != SUB0_ADDWF) begin
            aff[FLAG_Z] = 1'b1;
            st[FLAG_Z]  = r == 8'h00;
          end
          if (sub != SUB0_MISC) dest = ins[7] ? DEST_F : DEST_W;
        end
        OPG_BYTE1: begin
          case (sub)
            SUB1_MOVF: begin
              r = fv;
              aff[FLAG_Z] = 1'b1;
              st[FLAG_Z]  = fv == 8'h00;
            end
            SUB1_COMF: begin
              r = ~fv;
              aff[FLAG_Z] = 1'b1;
              st[FLAG_Z]  = fv == 8'hFF;
            end
            SUB1_INCF: begin
              r = inc_res;
              aff[FLAG_Z] = 1'b1;
              st[FLAG_Z]  = inc_res == 8'h00;
            end
            SUB1_DECFSZ: begin
              r = dec_res;
              if (dec_res == 8'h00) begin
                arch_nxt.pc  = pc_skip;
                res_o.cycles = CYC_TWO;
              end
            end
            SUB1_RRF: begin
              r = {arch.status[FLAG_C], fv[7:1]};
              aff[FLAG_C] = 1'b1;
              st[FLAG_C]  = fv[0];
            end
            SUB1_RLF: begin
              r = {fv[6:0], arch.status[FLAG_C]};
              aff[FLAG_C] = 1'b1;
              st[FLAG_C]  = fv[7];
            end
            SUB1_SWAPF: r = {fv[3:0], fv[7:4]};
            default: begin
              r = inc_res;
              if (inc_res == 8'h00) begin
                arch_nxt.pc  = pc_skip;
                res_o.cycles = CYC_TWO;
              end
            end
          endcase
          dest = ins[7] ? DEST_F : DEST_W;
        end
        OPG_BITSC: begin
          r    = ins[10] ? (fv | bmask) : (fv & ~bmask);
          dest = DEST_F;
        end
        OPG_BITTS: begin
          if (ins[10] ? bit_set : !bit_set) begin
            arch_nxt.pc  = pc_skip;
            res_o.cycles = CYC_TWO;
          end
        end
        OPG_CALL: begin
          stk.push     = 1'b1;
          arch_nxt.pc  = {pc_inc[12:11], ins[10:0]};
          res_o.cycles = CYC_TWO;
        end
        OPG_GOTO: begin
          arch_nxt.pc  = {pc_inc[12:11], ins[10:0]};
          res_o.cycles = CYC_TWO;
        end
        OPG_MOVLW: begin
          r    = lit;
          dest = DEST_W;
          if (ins[10]) begin
            stk.pop      = 1'b1;
            arch_nxt.pc  = pop_data;
            res_o.cycles = CYC_TWO;
          end
        end
        default: begin
          case (sub)
            SUBL_IORLW: begin
              r = arch.w | lit; dest = DEST_W; st[FLAG_Z] = r == 8'h00;
            end
            SUBL_ANDLW: begin
              r = arch.w & lit; dest = DEST_W; st[FLAG_Z] = r == 8'h00;
            end
            SUBL_XORLW: begin
              r = arch.w ^ lit; dest = DEST_W; st[FLAG_Z] = r == 8'h00;
            end
            SUBL_NOP: r = '0;
            SUBL_SUB0, SUBL_SUB1: begin
              r = sub_res; dest = DEST_W;
              st[FLAG_C] = sub_c; st[FLAG_DC] = sub_dc; st[FLAG_Z] = sub_z;
            end
            default: begin
              r = add_sum[7:0]; dest = DEST_W;
              st[FLAG_C]  = add_sum[8];
              st[FLAG_DC] = add_nib[4];
              st[FLAG_Z]  = add_sum[7:0] == 8'h00;
            end
          endcase
        end
      endcase

      // Write back to W or to the file; STATUS as target keeps TO, PD, own flags
      if (dest == DEST_W) begin
        arch_nxt.w = r;
      end else if (dest == DEST_F) begin
        res_o.file_write = 1'b1;
        res_o.file_addr  = fa;
        res_o.file_data  = r;
        if (fa == ADDR_STATUS) begin
          keep = aff;
          keep[FLAG_TO] = 1'b1;
          keep[FLAG_PD] = 1'b1;
          st = (r & ~keep) | (st & keep);
        end
      end
      arch_nxt.status = st;
    end

    res_o.pc_next      = arch_nxt.pc;
    res_o.w_value      = arch_nxt.w;
    res_o.status_value = arch_nxt.status;
    res_o.asleep       = arch_nxt.sleeping;
  end

endmodule

// ===== hdl/midrange_pic_instruction_executor.sv =====
// Top level of the mid-range PIC executor: input register, execute, result register.
// Depends on mpie_pkg, mpie_exec and mpie_stack.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  command, instruction, file_value, gie_now,
//                                          interrupt_pending
//   out_     output     out_valid/out_stall pc_next, w_value, status_value, file_*,
//                                          gie_set, gie_clear, cycles, stack_fault, asleep
//
// One transaction per clock unless stalled; out_valid rises when the result register loads.
// The single execute pass (decode, 8-bit adder, return stack read) sets the clock period.
// Synchronous active-low reset clears PC, W, stack pointer and sleep, and sets STATUS to 0x18.
// A stalled result holds; the input register keeps taking transactions until both stages fill.
`timescale 1ns / 1ps

module midrange_pic_instruction_executor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [13:0] in_instruction,
  input  logic [7:0]  in_file_value,
  input  logic        in_gie_now,
  input  logic        in_interrupt_pending,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [12:0] out_pc_next,
  output logic [7:0]  out_w_value,
  output logic [7:0]  out_status_value,
  output logic        out_file_write,
  output logic [6:0]  out_file_addr,
  output logic [7:0]  out_file_data,
  output logic        out_gie_set,
  output logic        out_gie_clear,
  output logic [1:0]  out_cycles,
  output logic [1:0]  out_stack_fault,
  output logic        out_asleep
);
  import mpie_pkg::*;

  item_t    item_r;
  logic     item_valid_r;
  result_t  res_r;
  result_t  res_nxt;
  result_t  exec_res;
  logic     out_valid_r;
  arch_t    arch_r;
  arch_t    arch_nxt;
  stk_ctl_t stk;
  logic [12:0] pop_data;
  logic [1:0]  fault;
  logic     adv;
  logic     in_accept;

  // Move the held transaction into the result register when it is free
  assign adv       = item_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = item_valid_r && out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  mpie_exec u_exec (
    .item     (item_r),
    .arch     (arch_r),
    .pop_data (pop_data),
    .arch_nxt (arch_nxt),
    .stk      (stk),
    .res_o    (exec_res)
  );

  mpie_stack u_stack (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .ctl      (stk),
    .pop_data (pop_data),
    .fault    (fault)
  );

  // Merge the stack fault into the result
  always_comb begin
    res_nxt             = exec_res;
    res_nxt.stack_fault = fault;
  end

  // Valid flags for both stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_accept) item_valid_r <= 1'b1;
      else if (adv)  item_valid_r <= 1'b0;
      if (adv)             out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Capture accepted transactions
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r.command           <= in_command;
      item_r.instruction       <= in_instruction;
      item_r.file_value        <= in_file_value;
      item_r.gie_now           <= in_gie_now;
      item_r.interrupt_pending <= in_interrupt_pending;
    end
  end

  // Hold results until taken
  always_ff @(posedge clk) begin
    if (adv) res_r <= res_nxt;
  end

  // Update core state on each executed transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arch_r.pc       <= '0;
      arch_r.w        <= '0;
      arch_r.status   <= STATUS_RESET;
      arch_r.sleeping <= 1'b0;
    end else if (adv) begin
      arch_r <= arch_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pc_next      = res_r.pc_next;
  assign out_w_value      = res_r.w_value;
  assign out_status_value = res_r.status_value;
  assign out_file_write   = res_r.file_write;
  assign out_file_addr    = res_r.file_addr;
  assign out_file_data    = res_r.file_data;
  assign out_gie_set      = res_r.gie_set;
  assign out_gie_clear    = res_r.gie_clear;
  assign out_cycles       = res_r.cycles;
  assign out_stack_fault  = res_r.stack_fault;
  assign out_asleep       = res_r.asleep;

endmodule

// ===== hdl/mpie_checker.sv =====
// Port-level checks for the mid-range PIC executor, bound to the top level.
// Depends on mpie_pkg for cycle and fault codes.
`timescale 1ns / 1ps

module mpie_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [12:0] out_pc_next,
  input logic        out_file_write,
  input logic [6:0]  out_file_addr,
  input logic [7:0]  out_file_data,
  input logic        out_gie_set,
  input logic        out_gie_clear,
  input logic [1:0]  out_cycles,
  input logic [1:0]  out_stack_fault
);
  import mpie_pkg::*;

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pc_next) && $stable(out_cycles))
    else $error("stalled result changed");

  // Drive address and data to zero when nothing is written back
  a_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_file_write |-> out_file_addr == 7'd0 && out_file_data == 8'd0)
    else $error("write-back fields set without write");

  // Vector an accepted interrupt to the fixed address and report the CYC_TWO cycle code
  a_vector: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_gie_clear |-> out_pc_next == INT_VECTOR && out_cycles == CYC_TWO)
    else $error("interrupt not vectored");

  // Report no side effects when no instruction ran
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cycles == CYC_NONE |->
      !out_file_write && !out_gie_set && out_stack_fault == FAULT_NONE)
    else $error("side effect without execution");

endmodule

bind midrange_pic_instruction_executor mpie_checker u_mpie_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_pc_next     (out_pc_next),
  .out_file_write  (out_file_write),
  .out_file_addr   (out_file_addr),
  .out_file_data   (out_file_data),
  .out_gie_set     (out_gie_set),
  .out_gie_clear   (out_gie_clear),
  .out_cycles      (out_cycles),
  .out_stack_fault (out_stack_fault)
);
